@@ rtl/assert_macros.svh @@
// Assertion macros shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check that is switched off while reset is held.
`define TMFS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked property check that also holds during reset.
`define TMFS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/tmfs_pkg.sv @@
// Shared constants, types and state encoding of the flow-shop scheduler.
package tmfs_pkg;

    localparam int MAX_JOBS    = 16;
    localparam int TIME_W      = 16;
    localparam int IDX_W       = $clog2(MAX_JOBS);
    localparam int CNT_W       = $clog2(MAX_JOBS + 1);
    localparam int JOB_INDEX_W = 4;
    localparam int SPAN_W      = 21;
    localparam int ACC_W       = TIME_W + $clog2(MAX_JOBS) + 1;
    localparam int S_TDATA_W   = ((2 * TIME_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((JOB_INDEX_W + SPAN_W + 7) / 8) * 8;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PICK,
        ST_CMP,
        ST_PLACE,
        ST_FETCH,
        ST_ADD,
        ST_FOLD,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic clear;
        logic add;
        logic fold;
    } span_ctrl_t;

endpackage

@@ rtl/tmfs_span_unit.sv @@
// Makespan accumulator: running machine-1 sum and machine-2 finish time.
module tmfs_span_unit (
    input  logic                      aclk,
    input  tmfs_pkg::span_ctrl_t      ctrl,
    input  logic [tmfs_pkg::TIME_W-1:0] time_a,
    input  logic [tmfs_pkg::TIME_W-1:0] time_b,
    output logic [tmfs_pkg::ACC_W-1:0]  makespan
);

    localparam int ACC_W  = tmfs_pkg::ACC_W;

    logic [ACC_W-1:0]            sum1_reg, sum1_next;
    logic [ACC_W-1:0]            fin2_reg, fin2_next;
    logic [tmfs_pkg::TIME_W-1:0] hold_b_reg, hold_b_next;
    logic [ACC_W-1:0]            larger;

    // The add step and the fold step sit in separate cycles so that each
    // path holds a single adder.
    always_comb begin
        larger      = (sum1_reg > fin2_reg) ? sum1_reg : fin2_reg;
        sum1_next   = sum1_reg;
        fin2_next   = fin2_reg;
        hold_b_next = hold_b_reg;
        if (ctrl.clear) begin
            sum1_next = '0;
            fin2_next = '0;
        end else if (ctrl.add) begin
            sum1_next   = sum1_reg + ACC_W'(time_a);
            hold_b_next = time_b;
        end else if (ctrl.fold) begin
            fin2_next = larger + ACC_W'(hold_b_reg);
        end
    end

    always_ff @(posedge aclk) begin
        sum1_reg   <= sum1_next;
        fin2_reg   <= fin2_next;
        hold_b_reg <= hold_b_next;
    end

    assign makespan = fin2_reg;

endmodule

@@ rtl/two_machine_flow_shop_scheduler.sv @@
// Top level: job store, Johnson's-rule rank sequencer and result register.
// Loading accepts jobs while s_tready is high; the set starts scheduling on the job with s_tlast.
// Ranking uses one shared key comparator that checks each stored job against every stored job.
// The makespan pass then fetches, adds and folds each job in turn, and emission gives one result
// per cycle while the output is not stalled by m_tready.
// aresetn (synchronous, active low) clears the job count, drop flag and state.
`include "assert_macros.svh"

module two_machine_flow_shop_scheduler (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [15:0] time_m1, [31:16] time_m2
    input  logic [tmfs_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [3:0] job_index, [24:4] makespan, [31:25] zero
    output logic [tmfs_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tlast,
    // [0] overflow
    output logic                           m_tuser
);

    localparam int MAX_JOBS = tmfs_pkg::MAX_JOBS;
    localparam int TIME_W   = tmfs_pkg::TIME_W;
    localparam int IDX_W    = tmfs_pkg::IDX_W;
    localparam int CNT_W    = tmfs_pkg::CNT_W;
    localparam int JIX_W    = tmfs_pkg::JOB_INDEX_W;
    localparam int SPAN_W   = tmfs_pkg::SPAN_W;
    localparam int ACC_W    = tmfs_pkg::ACC_W;
    localparam int PAD_W    = tmfs_pkg::M_TDATA_W - JIX_W - SPAN_W;

    tmfs_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic              dropped_reg, dropped_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic [IDX_W-1:0]  j_reg, j_next;
    logic [IDX_W-1:0]  rank_reg, rank_next;
    logic [TIME_W-1:0] cur_key_reg, cur_key_next;
    logic              cur_grp_reg, cur_grp_next;
    logic [IDX_W-1:0]  jsel_reg, jsel_next;

    logic              m_valid_reg, m_valid_next;
    logic [JIX_W-1:0]  m_index_reg, m_index_next;
    logic [SPAN_W-1:0] m_span_reg, m_span_next;
    logic              m_last_reg, m_last_next;
    logic              m_ovf_reg, m_ovf_next;

    // Job store: times for the makespan pass, key and group for ranking, and the ranked order.
    logic [TIME_W-1:0] m1_mem  [MAX_JOBS];
    logic [TIME_W-1:0] m2_mem  [MAX_JOBS];
    logic [TIME_W-1:0] key_mem [MAX_JOBS];
    logic              grp_mem [MAX_JOBS];
    logic [IDX_W-1:0]  ord_mem [MAX_JOBS];

    logic [TIME_W-1:0] in_m1, in_m2;
    logic              s_acc;
    logic              job_we;
    logic              ord_we;
    logic [IDX_W-1:0]  ord_addr;
    logic [IDX_W-1:0]  last_idx;
    logic              i_at_end, j_at_end;
    logic [IDX_W-1:0]  rank_rd_idx;
    logic [TIME_W-1:0] key_rd;
    logic              grp_rd;
    logic [IDX_W-1:0]  ord_rd;
    logic              hit;
    logic              out_free;
    logic [ACC_W-1:0]  makespan;

    tmfs_pkg::span_ctrl_t span_ctrl;

    assign in_m1    = s_tdata[TIME_W-1:0];
    assign in_m2    = s_tdata[2*TIME_W-1:TIME_W];
    assign s_acc    = s_tvalid && s_tready;
    assign last_idx = IDX_W'(count_reg - CNT_W'(1));
    assign i_at_end = (i_reg == last_idx);
    assign j_at_end = (j_reg == last_idx);
    assign out_free = !m_valid_reg || m_tready;

    assign rank_rd_idx = (state_reg == tmfs_pkg::ST_PICK) ? i_reg : j_reg;
    assign key_rd      = key_mem[rank_rd_idx];
    assign grp_rd      = grp_mem[rank_rd_idx];
    assign ord_rd      = ord_mem[i_reg];

    // Job j counts toward the current job's rank when it belongs to the same
    // group and has a smaller key, or an equal key and a later arrival.
    assign hit = (grp_rd == cur_grp_reg) &&
                 ((key_rd < cur_key_reg) || ((key_rd == cur_key_reg) && (j_reg > i_reg)));

    // The front group fills upward from position zero, the back group
    // downward from the last position.
    assign ord_addr = cur_grp_reg ? rank_reg
                                  : IDX_W'(count_reg - CNT_W'(1) - CNT_W'(rank_reg));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tmfs_pkg::ST_LOAD: begin
                if (s_acc && s_tlast) begin
                    state_next = tmfs_pkg::ST_PICK;
                end
            end
            tmfs_pkg::ST_PICK:  state_next = tmfs_pkg::ST_CMP;
            tmfs_pkg::ST_CMP: begin
                if (j_at_end) begin
                    state_next = tmfs_pkg::ST_PLACE;
                end
            end
            tmfs_pkg::ST_PLACE: begin
                state_next = i_at_end ? tmfs_pkg::ST_FETCH : tmfs_pkg::ST_PICK;
            end
            tmfs_pkg::ST_FETCH: state_next = tmfs_pkg::ST_ADD;
            tmfs_pkg::ST_ADD:   state_next = tmfs_pkg::ST_FOLD;
            tmfs_pkg::ST_FOLD: begin
                state_next = i_at_end ? tmfs_pkg::ST_EMIT : tmfs_pkg::ST_FETCH;
            end
            tmfs_pkg::ST_EMIT: begin
                if (out_free && i_at_end) begin
                    state_next = tmfs_pkg::ST_LOAD;
                end
            end
            default: state_next = tmfs_pkg::ST_LOAD;
        endcase
    end

    always_comb begin
        s_tready      = 1'b0;
        job_we        = 1'b0;
        ord_we        = 1'b0;
        span_ctrl     = '0;
        count_next    = count_reg;
        dropped_next  = dropped_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        rank_next     = rank_reg;
        cur_key_next  = cur_key_reg;
        cur_grp_next  = cur_grp_reg;
        jsel_next     = jsel_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_index_next  = m_index_reg;
        m_span_next   = m_span_reg;
        m_last_next   = m_last_reg;
        m_ovf_next    = m_ovf_reg;
        unique case (state_reg)
            tmfs_pkg::ST_LOAD: begin
                s_tready = 1'b1;
                if (s_acc) begin
                    if (count_reg < CNT_W'(MAX_JOBS)) begin
                        job_we     = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end else begin
                        dropped_next = 1'b1;
                    end
                    if (s_tlast) begin
                        i_next = '0;
                    end
                end
            end
            tmfs_pkg::ST_PICK: begin
                cur_key_next = key_rd;
                cur_grp_next = grp_rd;
                j_next       = '0;
                rank_next    = '0;
            end
            tmfs_pkg::ST_CMP: begin
                rank_next = rank_reg + IDX_W'(hit);
                j_next    = j_reg + IDX_W'(1);
            end
            tmfs_pkg::ST_PLACE: begin
                ord_we = 1'b1;
                i_next = i_at_end ? '0 : i_reg + IDX_W'(1);
                if (i_at_end) begin
                    span_ctrl.clear = 1'b1;
                end
            end
            tmfs_pkg::ST_FETCH: begin
                jsel_next = ord_rd;
            end
            tmfs_pkg::ST_ADD: begin
                span_ctrl.add = 1'b1;
            end
            tmfs_pkg::ST_FOLD: begin
                span_ctrl.fold = 1'b1;
                i_next = i_at_end ? '0 : i_reg + IDX_W'(1);
            end
            tmfs_pkg::ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_index_next = JIX_W'(ord_rd);
                    m_span_next  = SPAN_W'(makespan);
                    m_last_next  = i_at_end;
                    m_ovf_next   = dropped_reg;
                    if (i_at_end) begin
                        count_next   = '0;
                        dropped_next = 1'b0;
                    end else begin
                        i_next = i_reg + IDX_W'(1);
                    end
                end
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tmfs_pkg::ST_LOAD;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            i_reg       <= '0;
            j_reg       <= '0;
            rank_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            rank_reg    <= rank_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_key_reg <= cur_key_next;
        cur_grp_reg <= cur_grp_next;
        jsel_reg    <= jsel_next;
        m_index_reg <= m_index_next;
        m_span_reg  <= m_span_next;
        m_last_reg  <= m_last_next;
        m_ovf_reg   <= m_ovf_next;
    end

    // The key is the smaller time; the group bit marks a front-group job.
    always_ff @(posedge aclk) begin
        if (job_we) begin
            m1_mem[count_reg[IDX_W-1:0]]  <= in_m1;
            m2_mem[count_reg[IDX_W-1:0]]  <= in_m2;
            key_mem[count_reg[IDX_W-1:0]] <= (in_m1 < in_m2) ? in_m1 : in_m2;
            grp_mem[count_reg[IDX_W-1:0]] <= (in_m1 <= in_m2);
        end
    end

    always_ff @(posedge aclk) begin
        if (ord_we) begin
            ord_mem[ord_addr] <= i_reg;
        end
    end

    tmfs_span_unit u_span (
        .aclk     (aclk),
        .ctrl     (span_ctrl),
        .time_a   (m1_mem[jsel_reg]),
        .time_b   (m2_mem[jsel_reg]),
        .makespan (makespan)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {PAD_W'(0), m_span_reg, m_index_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_ovf_reg;

    `TMFS_ASSERT(a_last_starts_rank, aclk, aresetn, (s_acc && s_tlast) |=> (state_reg == tmfs_pkg::ST_PICK), "last request did not start ranking")
    `TMFS_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(MAX_JOBS), "job count beyond capacity")
    `TMFS_ASSERT(a_emit_nonempty, aclk, aresetn, (state_reg == tmfs_pkg::ST_EMIT) |-> (count_reg != '0), "emitting an empty set")
    `TMFS_ASSERT(a_emit_done_clears, aclk, aresetn, (state_reg == tmfs_pkg::ST_EMIT && out_free && i_at_end) |=> (state_reg == tmfs_pkg::ST_LOAD && count_reg == '0 && !dropped_reg && m_tlast), "set not cleared after final result")

endmodule
